>>> hdl/cac_pkg.sv
`timescale 1ns / 1ps
package cac_pkg;

  // field widths
  localparam int VOLT_W  = 13;
  localparam int CMD_W   = 2;
  localparam int CNT_W   = 4;
  localparam int TPAR_W  = 3;
  localparam int P_W     = 9;
  localparam int N_W     = 16;
  localparam int NREG_W  = 7;
  localparam int CFG_IDX_W = 2;

  // array size and threshold reset values in millivolts
  localparam logic [CNT_W-1:0]  NUM_CAPS       = 4'd8;
  localparam logic [VOLT_W-1:0] ADD_SERIES_RST = 13'd2970;
  localparam logic [VOLT_W-1:0] BROWNOUT_RST   = 13'd2700;
  localparam logic [VOLT_W-1:0] FULL_RST       = 13'd3290;

  // charge fraction 0.9 as numerator over denominator
  localparam int FRAC_NUM = 9;
  localparam int FRAC_DEN = 10;
  localparam int PROD_W   = VOLT_W + 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALL_SERIES  = 2'd0,
    CMD_CHARGE_STEP = 2'd1,
    CMD_ISOLATE     = 2'd2,
    CMD_BROWNOUT    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADD_SERIES = 2'd0,
    CFG_BROWNOUT   = 2'd1,
    CFG_FULL       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [VOLT_W-1:0] voc_mv;
    logic [VOLT_W-1:0] vcap_mv;
  } cac_in_t;

  typedef struct packed {
    logic [P_W-1:0]    p_switches;
    logic [N_W-1:0]    n_switches;
    logic              harvester_on;
    logic              load_on;
    logic [CNT_W-1:0]  charge_parallel;
    logic [CNT_W-1:0]  charge_series;
    logic [CNT_W-1:0]  task_series;
    logic [TPAR_W-1:0] task_parallel;
    logic              isolated;
  } cac_out_t;

endpackage

>>> hdl/cac_if.sv
`timescale 1ns / 1ps
// command item channel
interface cac_in_if;
  import cac_pkg::*;
  logic    valid;
  logic    ready;
  cac_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// switch state item channel
interface cac_out_if;
  import cac_pkg::*;
  logic     valid;
  logic     ready;
  cac_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/capacitor_array_reconfig_controller.sv
`timescale 1ns / 1ps
// Switch controller for an eight-capacitor harvesting array. One command item is
// accepted per clock cycle while the input is not stalled behind a held result. Each
// item yields exactly one result item, which carries the switch vectors and
// arrangement counts after that command. The input register loads at the accepting
// edge, and the state register, which also serves as the result register, loads
// from it when the result slot is free or being taken. Every item updates the switch
// and count registers in order. Thresholds are to be written through the cfg port only
// while no item is in flight; the user must keep to this, as the block does not enforce it.
module capacitor_array_reconfig_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  cac_in_if.sink                         in_ch,
  cac_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cac_pkg::VOLT_W-1:0]     cfg_wdata
);
  import cac_pkg::*;

  // threshold registers
  logic [VOLT_W-1:0] add_series_r, brownout_r, full_r;

  // input stage
  logic    s1_valid_r;
  cac_in_t s1_data_r;

  // switch and count state, also the result register
  logic              out_valid_r;
  logic [P_W-1:0]    pos_r, pos_nxt;
  logic [NREG_W-1:0] neg_r, neg_nxt;
  logic              harv_r, harv_nxt;
  logic              load_r, load_nxt;
  logic [CNT_W-1:0]  cpar_r, cpar_nxt;
  logic [CNT_W-1:0]  cser_r, cser_nxt;
  logic [CNT_W-1:0]  tser_r, tser_nxt;
  logic [TPAR_W-1:0] tpar_r, tpar_nxt;
  logic              iso_r, iso_nxt;

  logic              adv;
  logic [PROD_W-1:0] vcap_x_den, voc_x_num;
  logic              frac_ok;
  logic [CNT_W-1:0]  par_new;

  // handshake: stage advances when the result slot is free or being taken
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv || !s1_valid_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_series_r <= ADD_SERIES_RST;
      brownout_r   <= BROWNOUT_RST;
      full_r       <= FULL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ADD_SERIES: add_series_r <= cfg_wdata;
        CFG_BROWNOUT:   brownout_r   <= cfg_wdata;
        CFG_FULL:       full_r       <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
  end

  // vcap > 0.9 * voc as 10 * vcap > 9 * voc
  assign vcap_x_den = {{(PROD_W-VOLT_W){1'b0}}, s1_data_r.vcap_mv} * PROD_W'(FRAC_DEN);
  assign voc_x_num  = {{(PROD_W-VOLT_W){1'b0}}, s1_data_r.voc_mv} * PROD_W'(FRAC_NUM);
  assign frac_ok    = vcap_x_den > voc_x_num;

  // first parallel step jumps to two capacitors
  assign par_new = (cpar_r == '0) ? 4'd2 : cpar_r + 4'd1;

  // next switch and count state
  always_comb begin
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    harv_nxt = harv_r;
    load_nxt = load_r;
    cpar_nxt = cpar_r;
    cser_nxt = cser_r;
    tser_nxt = tser_r;
    tpar_nxt = tpar_r;
    iso_nxt  = iso_r;
    case (cmd_t'(s1_data_r.cmd))
      CMD_ALL_SERIES: begin
        harv_nxt = 1'b1;
        load_nxt = 1'b0;
        pos_nxt  = P_W'(1);
        neg_nxt  = '1;
        cser_nxt = NUM_CAPS;
        cpar_nxt = '0;
      end
      CMD_CHARGE_STEP: begin
        // add one capacitor to the parallel group
        if (frac_ok && cpar_r != 4'd1 && cpar_r < NUM_CAPS) begin
          for (int i = 0; i < 8; i++) begin
            if (CNT_W'(i) >= 4'd9 - par_new) pos_nxt[i] = 1'b1;
          end
          for (int i = 0; i < NREG_W; i++) begin
            if (CNT_W'(i) >= 4'd8 - par_new) neg_nxt[i] = 1'b0;
          end
          pos_nxt[P_W-1] = 1'b0;
          cpar_nxt       = par_new;
          cser_nxt       = NUM_CAPS - par_new;
        end
        // full test after the add
        if (cpar_nxt == NUM_CAPS && s1_data_r.vcap_mv > full_r) iso_nxt = 1'b1;
        harv_nxt   = 1'b1;
        load_nxt   = 1'b0;
        pos_nxt[0] = 1'b1;
      end
      CMD_ISOLATE: begin
        harv_nxt   = 1'b0;
        pos_nxt[0] = 1'b0;
        load_nxt   = 1'b1;
        tpar_nxt   = 3'd7;
        tser_nxt   = 4'd1;
      end
      default: begin
        load_nxt = 1'b0;
        harv_nxt = 1'b0;
        if (s1_data_r.vcap_mv <= add_series_r && tser_r != NUM_CAPS) begin
          // add one task capacitor to series
          if (tser_r >= 4'd1 && tser_r <= 4'd7) begin
            for (int i = 0; i < NREG_W; i++) begin
              if (CNT_W'(i) < tser_r) neg_nxt[i] = 1'b1;
            end
            for (int i = 1; i < 8; i++) begin
              if (CNT_W'(i) <= tser_r) pos_nxt[i] = 1'b0;
            end
            if (tser_r == 4'd7) pos_nxt[P_W-1] = 1'b0;
            harv_nxt = 1'b1;
            tser_nxt = tser_r + 4'd1;
            tpar_nxt = 3'd7 - tser_r[TPAR_W-1:0];
          end
        end else if (s1_data_r.vcap_mv <= brownout_r) begin
          iso_nxt = 1'b0;
        end
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      neg_r       <= '0;
      harv_r      <= 1'b0;
      load_r      <= 1'b0;
      cpar_r      <= '0;
      cser_r      <= '0;
      tser_r      <= '0;
      tpar_r      <= '0;
      iso_r       <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        pos_r  <= pos_nxt;
        neg_r  <= neg_nxt;
        harv_r <= harv_nxt;
        load_r <= load_nxt;
        cpar_r <= cpar_nxt;
        cser_r <= cser_nxt;
        tser_r <= tser_nxt;
        tpar_r <= tpar_nxt;
        iso_r  <= iso_nxt;
      end
    end
  end

  // result item
  assign out_ch.valid                = out_valid_r;
  assign out_ch.data.p_switches      = pos_r;
  assign out_ch.data.n_switches      = {{(N_W-NREG_W){1'b0}}, neg_r};
  assign out_ch.data.harvester_on    = harv_r;
  assign out_ch.data.load_on         = load_r;
  assign out_ch.data.charge_parallel = cpar_r;
  assign out_ch.data.charge_series   = cser_r;
  assign out_ch.data.task_series     = tser_r;
  assign out_ch.data.task_parallel   = tpar_r;
  assign out_ch.data.isolated        = iso_r;

`ifndef SYNTHESIS
  // charging arrangement always covers the whole array once set up
  assert property (@(posedge clk) disable iff (!rst_n)
    (cpar_r != '0 || cser_r != '0) |-> ({1'b0, cpar_r} + {1'b0, cser_r} == 5'd8))
    else $error("charge counts do not add up to the array size");

  // task arrangement always covers the whole array once set up
  assert property (@(posedge clk) disable iff (!rst_n)
    (tser_r != '0 || tpar_r != '0) |-> ({1'b0, tser_r} + {2'b0, tpar_r} == 5'd8))
    else $error("task counts do not add up to the array size");

  // flag only sets with the array fully parallel
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(iso_r) |-> (cpar_r == NUM_CAPS))
    else $error("isolated flag set without a fully parallel array");

  // harvester and load paths never closed together
  assert property (@(posedge clk) disable iff (!rst_n)
    !(harv_r && load_r))
    else $error("harvester and load switches closed together");

  // input stalls only behind a held item
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline");
`endif

endmodule
